[src/hics_pkg.sv]
// Shared constants, codes and controller/datapath types for the histogram sampler.
package hics_pkg;

	// Table geometry.
	localparam int MAX_BINS = 256;
	localparam int DEPTH    = MAX_BINS + 1;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int BIN_W    = 9;

	// Fixed-point widths.
	localparam int BND_W = 32;
	localparam int CUM_W = 64;
	localparam int CDF_W = 33;

	// Probability one in Q1.32.
	localparam logic [CDF_W-1:0] CDF_ONE = {1'b1, 32'h0};

	// Request action codes.
	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_READY = 2'd1,
		STAT_ZERO_BIN  = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	// Datapath operations, one per cycle.
	typedef enum logic [5:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_START_TABLE,
		OP_SET_NOT_READY,
		OP_SET_ZERO_BIN,
		OP_SET_FULL,
		OP_CAP_TOP,
		OP_CAP_B0,
		OP_CDF_FULL,
		OP_SRCH_INIT,
		OP_SRCH_X,
		OP_SRCH_C,
		OP_CAP_LO,
		OP_CAP_HI,
		OP_WIDTH,
		OP_DIV_H,
		OP_CAP_H,
		OP_DIV_PDF,
		OP_CAP_PDF,
		OP_MUL_AREA,
		OP_AREA,
		OP_DIV_CDF,
		OP_CAP_CDF,
		OP_LIM_B0,
		OP_SEL_AREA,
		OP_SEL_TOTAL,
		OP_MUL_RHI,
		OP_MUL_RLO,
		OP_R_SUM,
		OP_DIV_F,
		OP_CAP_F,
		OP_MUL_OFF,
		OP_DRAWN,
		OP_APP_BND,
		OP_MUL_APP,
		OP_APP_WRITE,
		OP_OUT_LOAD
	} dp_op_t;

	// Read address source for both stores.
	typedef enum logic [2:0] {
		RD_ZERO,
		RD_LAST,
		RD_MID,
		RD_LO,
		RD_LO1
	} rd_sel_t;

	typedef struct packed {
		dp_op_t  op;
		rd_sel_t rd;
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    n_zero;
		logic    n_lt2;
		logic    n_full;
		logic    total_zero;
		logic    in_range;
		logic    x_ge_top;
		logic    x_le_b0;
		logic    use_limit;
		logic    area_zero;
		logic    srch_more;
		logic    div_done;
		logic    out_free;
	} dp_sts_t;

	// Controller states.
	typedef enum logic [5:0] {
		S_IDLE,
		S_DISPATCH,
		S_APP_CAP,
		S_APP_BND,
		S_APP_MUL,
		S_APP_WR,
		S_Q_TOP,
		S_Q_B0,
		S_Q_CHECK,
		S_XS_ISSUE,
		S_XS_CMP,
		S_XB_CAPLO,
		S_XB_CAPHI,
		S_XB_WIDTH,
		S_XH_START,
		S_XH_WAIT,
		S_XP_START,
		S_XP_WAIT,
		S_XA_MUL,
		S_XA_SUM,
		S_XC_START,
		S_XC_WAIT,
		S_SMP,
		S_D_RHI,
		S_D_RLO,
		S_D_RSUM,
		S_CS_ISSUE,
		S_CS_CMP,
		S_DB_CAPLO,
		S_DB_CAPHI,
		S_DB_WIDTH,
		S_DF_START,
		S_DF_WAIT,
		S_DM_MUL,
		S_DM_SUM,
		S_DONE
	} ctrl_state_t;

endpackage

[src/hics_if.sv]
// Request and response channel interfaces of the histogram sampler.
interface hics_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] x;
	logic [31:0]        value;
	logic [31:0]        u;
	logic               use_limit;

	modport source (output valid, action, x, value, u, use_limit, input ready);
	modport sink   (input valid, action, x, value, u, use_limit, output ready);
endinterface

interface hics_rsp_if;
	logic               valid;
	logic               ready;
	logic [31:0]        pdf;
	logic [31:0]        density;
	logic [32:0]        cdf;
	logic signed [31:0] drawn;
	logic [8:0]         bin_index;
	logic [1:0]         status;

	modport source (output valid, pdf, density, cdf, drawn, bin_index, status, input ready);
	modport sink   (input valid, pdf, density, cdf, drawn, bin_index, status, output ready);
endinterface

[src/histogram_inverse_cdf_sampler.sv]
// Top level of the histogram inverse-CDF sampler.
//
//   Channel  Direction  Carries
//   req      in         action, x, value, u, use_limit (valid/ready)
//   rsp      out        pdf, density, cdf, drawn, bin_index, status (valid/ready)
//   cfg      in         values_are_cdf (cfg_wen/cfg_wdata, no read-back)
//
// One request is worked on at a time. A start, a rejected or a no-operation request goes
// straight to its result; an append reads the last entry, clamps, accumulates and writes; a
// query runs up to four quotients on the shared divider and up to two binary searches.
// The stores need no clearing after reset; reset empties the table through the entry count.
// A finished result waits in the output register while the next request is taken.
module histogram_inverse_cdf_sampler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	hics_req_if.sink   req,
	hics_rsp_if.source rsp
);

	hics_pkg::dp_cmd_t cmd;
	hics_pkg::dp_sts_t sts;

	hics_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hics_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.in_action     (req.action),
		.in_x          (req.x),
		.in_value      (req.value),
		.in_u          (req.u),
		.in_use_limit  (req.use_limit),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_pdf       (rsp.pdf),
		.out_density   (rsp.density),
		.out_cdf       (rsp.cdf),
		.out_drawn     (rsp.drawn),
		.out_bin_index (rsp.bin_index),
		.out_status    (rsp.status)
	);

endmodule

[src/hics_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hics_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 257
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/hics_div.sv]
// Restoring divider: floor((hi * 2^32 + lo) / den), one quotient bit per cycle.
module hics_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] hi,
	input  logic [31:0] lo,
	input  logic [63:0] den,
	output logic        done,
	output logic [32:0] q
);

	localparam int STEPS = 32;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [63:0]       rem_q;
	logic [31:0]       lo_q;
	logic [63:0]       den_q;
	logic [31:0]       quo_q;
	logic              sat_q;
	logic [64:0]       trial;
	logic              take;

	// One trial subtraction per cycle.
	assign trial = {rem_q, lo_q[31]};
	assign take  = trial >= {1'b0, den_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi;
			lo_q  <= lo;
			den_q <= den;
			quo_q <= '0;
			sat_q <= hi >= den;
		end else if (run_q) begin
			rem_q <= take ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], take};
		end
	end

	// A quotient of 2^32 or more reports as exactly 2^32.
	assign done = done_q;
	assign q    = sat_q ? {1'b1, 32'h0} : {1'b0, quo_q};

endmodule

[src/hics_ctrl.sv]
// Controller state machine sequencing loads and queries over the datapath.
module hics_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hics_pkg::dp_sts_t sts,
	output hics_pkg::dp_cmd_t cmd
);

	hics_pkg::ctrl_state_t state_q;
	hics_pkg::ctrl_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hics_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd.op    = hics_pkg::OP_NOP;
		cmd.rd    = hics_pkg::RD_ZERO;
		case (state_q)
			hics_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op    = hics_pkg::OP_ACCEPT;
					state_nxt = hics_pkg::S_DISPATCH;
				end
			end
			hics_pkg::S_DISPATCH: begin
				cmd.rd = hics_pkg::RD_LAST;
				case (sts.action)
					hics_pkg::ACT_START: begin
						cmd.op    = hics_pkg::OP_START_TABLE;
						state_nxt = hics_pkg::S_DONE;
					end
					hics_pkg::ACT_APPEND: begin
						if (sts.n_zero) begin
							cmd.op    = hics_pkg::OP_SET_NOT_READY;
							state_nxt = hics_pkg::S_DONE;
						end else if (sts.n_full) begin
							cmd.op    = hics_pkg::OP_SET_FULL;
							state_nxt = hics_pkg::S_DONE;
						end else begin
							state_nxt = hics_pkg::S_APP_CAP;
						end
					end
					hics_pkg::ACT_QUERY: begin
						if (sts.n_lt2) begin
							cmd.op    = hics_pkg::OP_SET_NOT_READY;
							state_nxt = hics_pkg::S_DONE;
						end else begin
							state_nxt = hics_pkg::S_Q_TOP;
						end
					end
					default: begin
						state_nxt = hics_pkg::S_DONE;
					end
				endcase
			end

			// Append: read the last entry, clamp, accumulate, write.
			hics_pkg::S_APP_CAP: begin
				cmd.op    = hics_pkg::OP_CAP_LO;
				state_nxt = hics_pkg::S_APP_BND;
			end
			hics_pkg::S_APP_BND: begin
				cmd.op    = hics_pkg::OP_APP_BND;
				state_nxt = hics_pkg::S_APP_MUL;
			end
			hics_pkg::S_APP_MUL: begin
				cmd.op    = hics_pkg::OP_MUL_APP;
				state_nxt = hics_pkg::S_APP_WR;
			end
			hics_pkg::S_APP_WR: begin
				cmd.op    = hics_pkg::OP_APP_WRITE;
				state_nxt = hics_pkg::S_DONE;
			end

			// Query: fetch the table's ends.
			hics_pkg::S_Q_TOP: begin
				cmd.op    = hics_pkg::OP_CAP_TOP;
				cmd.rd    = hics_pkg::RD_ZERO;
				state_nxt = hics_pkg::S_Q_B0;
			end
			hics_pkg::S_Q_B0: begin
				cmd.op    = hics_pkg::OP_CAP_B0;
				state_nxt = hics_pkg::S_Q_CHECK;
			end
			hics_pkg::S_Q_CHECK: begin
				if (sts.total_zero) begin
					cmd.op    = hics_pkg::OP_SET_ZERO_BIN;
					state_nxt = hics_pkg::S_DONE;
				end else if (sts.in_range) begin
					cmd.op    = hics_pkg::OP_SRCH_INIT;
					state_nxt = hics_pkg::S_XS_ISSUE;
				end else begin
					if (sts.x_ge_top) begin
						cmd.op = hics_pkg::OP_CDF_FULL;
					end
					state_nxt = hics_pkg::S_SMP;
				end
			end

			// Search for the bin holding x.
			hics_pkg::S_XS_ISSUE: begin
				if (sts.srch_more) begin
					cmd.rd    = hics_pkg::RD_MID;
					state_nxt = hics_pkg::S_XS_CMP;
				end else begin
					cmd.rd    = hics_pkg::RD_LO;
					state_nxt = hics_pkg::S_XB_CAPLO;
				end
			end
			hics_pkg::S_XS_CMP: begin
				cmd.op    = hics_pkg::OP_SRCH_X;
				state_nxt = hics_pkg::S_XS_ISSUE;
			end
			hics_pkg::S_XB_CAPLO: begin
				cmd.op    = hics_pkg::OP_CAP_LO;
				cmd.rd    = hics_pkg::RD_LO1;
				state_nxt = hics_pkg::S_XB_CAPHI;
			end
			hics_pkg::S_XB_CAPHI: begin
				cmd.op    = hics_pkg::OP_CAP_HI;
				state_nxt = hics_pkg::S_XB_WIDTH;
			end
			hics_pkg::S_XB_WIDTH: begin
				cmd.op    = hics_pkg::OP_WIDTH;
				state_nxt = hics_pkg::S_XH_START;
			end

			// Density, then normalised density.
			hics_pkg::S_XH_START: begin
				cmd.op    = hics_pkg::OP_DIV_H;
				state_nxt = hics_pkg::S_XH_WAIT;
			end
			hics_pkg::S_XH_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = hics_pkg::OP_CAP_H;
					state_nxt = hics_pkg::S_XP_START;
				end
			end
			hics_pkg::S_XP_START: begin
				cmd.op    = hics_pkg::OP_DIV_PDF;
				state_nxt = hics_pkg::S_XP_WAIT;
			end
			hics_pkg::S_XP_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = hics_pkg::OP_CAP_PDF;
					state_nxt = hics_pkg::S_XA_MUL;
				end
			end

			// Cumulative area at x and the cdf.
			hics_pkg::S_XA_MUL: begin
				if (sts.x_ge_top) begin
					cmd.op    = hics_pkg::OP_CDF_FULL;
					state_nxt = hics_pkg::S_SMP;
				end else begin
					cmd.op    = hics_pkg::OP_MUL_AREA;
					state_nxt = hics_pkg::S_XA_SUM;
				end
			end
			hics_pkg::S_XA_SUM: begin
				cmd.op    = hics_pkg::OP_AREA;
				state_nxt = hics_pkg::S_XC_START;
			end
			hics_pkg::S_XC_START: begin
				cmd.op    = hics_pkg::OP_DIV_CDF;
				state_nxt = hics_pkg::S_XC_WAIT;
			end
			hics_pkg::S_XC_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = hics_pkg::OP_CAP_CDF;
					state_nxt = hics_pkg::S_SMP;
				end
			end

			// Choose the sampling span.
			hics_pkg::S_SMP: begin
				if (sts.use_limit && !sts.x_ge_top) begin
					if (sts.x_le_b0) begin
						cmd.op    = hics_pkg::OP_LIM_B0;
						state_nxt = hics_pkg::S_DONE;
					end else if (sts.area_zero) begin
						cmd.op    = hics_pkg::OP_SET_ZERO_BIN;
						state_nxt = hics_pkg::S_DONE;
					end else begin
						cmd.op    = hics_pkg::OP_SEL_AREA;
						state_nxt = hics_pkg::S_D_RHI;
					end
				end else begin
					cmd.op    = hics_pkg::OP_SEL_TOTAL;
					state_nxt = hics_pkg::S_D_RHI;
				end
			end

			// Scale the uniform number onto the span.
			hics_pkg::S_D_RHI: begin
				cmd.op    = hics_pkg::OP_MUL_RHI;
				state_nxt = hics_pkg::S_D_RLO;
			end
			hics_pkg::S_D_RLO: begin
				cmd.op    = hics_pkg::OP_MUL_RLO;
				state_nxt = hics_pkg::S_D_RSUM;
			end
			hics_pkg::S_D_RSUM: begin
				cmd.op    = hics_pkg::OP_R_SUM;
				state_nxt = hics_pkg::S_CS_ISSUE;
			end

			// Search for the bin holding the scaled number.
			hics_pkg::S_CS_ISSUE: begin
				if (sts.srch_more) begin
					cmd.rd    = hics_pkg::RD_MID;
					state_nxt = hics_pkg::S_CS_CMP;
				end else begin
					cmd.rd    = hics_pkg::RD_LO;
					state_nxt = hics_pkg::S_DB_CAPLO;
				end
			end
			hics_pkg::S_CS_CMP: begin
				cmd.op    = hics_pkg::OP_SRCH_C;
				state_nxt = hics_pkg::S_CS_ISSUE;
			end
			hics_pkg::S_DB_CAPLO: begin
				cmd.op    = hics_pkg::OP_CAP_LO;
				cmd.rd    = hics_pkg::RD_LO1;
				state_nxt = hics_pkg::S_DB_CAPHI;
			end
			hics_pkg::S_DB_CAPHI: begin
				cmd.op    = hics_pkg::OP_CAP_HI;
				state_nxt = hics_pkg::S_DB_WIDTH;
			end
			hics_pkg::S_DB_WIDTH: begin
				cmd.op    = hics_pkg::OP_WIDTH;
				state_nxt = hics_pkg::S_DF_START;
			end

			// Fraction within the bin and the drawn value.
			hics_pkg::S_DF_START: begin
				cmd.op    = hics_pkg::OP_DIV_F;
				state_nxt = hics_pkg::S_DF_WAIT;
			end
			hics_pkg::S_DF_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = hics_pkg::OP_CAP_F;
					state_nxt = hics_pkg::S_DM_MUL;
				end
			end
			hics_pkg::S_DM_MUL: begin
				cmd.op    = hics_pkg::OP_MUL_OFF;
				state_nxt = hics_pkg::S_DM_SUM;
			end
			hics_pkg::S_DM_SUM: begin
				cmd.op    = hics_pkg::OP_DRAWN;
				state_nxt = hics_pkg::S_DONE;
			end

			// Hand the result to the output register once it is free.
			hics_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.op    = hics_pkg::OP_OUT_LOAD;
					state_nxt = hics_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = hics_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[src/hics_dp.sv]
// Datapath: table stores, search registers, multiplier, divider and result registers.
module hics_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hics_pkg::dp_cmd_t    cmd,
	output hics_pkg::dp_sts_t    sts,
	input  logic                 cfg_wen,
	input  logic                 cfg_wdata,
	input  logic [1:0]           in_action,
	input  logic signed [31:0]   in_x,
	input  logic [31:0]          in_value,
	input  logic [31:0]          in_u,
	input  logic                 in_use_limit,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [31:0]          out_pdf,
	output logic [31:0]          out_density,
	output logic [32:0]          out_cdf,
	output logic signed [31:0]   out_drawn,
	output logic [8:0]           out_bin_index,
	output logic [1:0]           out_status
);

	localparam int IW = hics_pkg::IDX_W;
	localparam int CW = hics_pkg::CNT_W;
	localparam int BW = hics_pkg::BND_W;
	localparam int UW = hics_pkg::CUM_W;

	// Control state.
	logic          cfg_q;
	logic [CW-1:0] n_q;
	logic          out_valid_q;

	// Item registers.
	hics_pkg::action_t act_q;
	logic [BW-1:0]     x_q;
	logic [31:0]       val_q;
	logic [31:0]       u_q;
	logic              lim_q;

	// Working registers.
	logic [UW-1:0] total_q;
	logic [BW-1:0] b0_q;
	logic [BW-1:0] btop_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic [BW-1:0] bi_q;
	logic [BW-1:0] bi1_q;
	logic [UW-1:0] ci_q;
	logic [UW-1:0] ci1_q;
	logic [BW-1:0] w_q;
	logic [UW-1:0] a_q;
	logic [31:0]   h_q;
	logic [63:0]   prod_q;
	logic [UW-1:0] area_q;
	logic [UW-1:0] s_q;
	logic [UW-1:0] r_q;
	logic [32:0]   f_q;

	// Result registers of the item in flight.
	logic [31:0]                   pdf_q;
	logic [31:0]                   dens_q;
	logic [hics_pkg::CDF_W-1:0]    cdf_q;
	logic [BW-1:0]                 drawn_q;
	logic [hics_pkg::BIN_W-1:0]    bidx_q;
	hics_pkg::status_t             stat_q;

	// Output register.
	logic [31:0]                   opdf_q;
	logic [31:0]                   odens_q;
	logic [hics_pkg::CDF_W-1:0]    ocdf_q;
	logic [BW-1:0]                 odrawn_q;
	logic [hics_pkg::BIN_W-1:0]    obidx_q;
	hics_pkg::status_t             ostat_q;

	// Store ports.
	logic          we;
	logic [IW-1:0] waddr;
	logic [BW-1:0] wdata_b;
	logic [UW-1:0] wdata_c;
	logic [IW-1:0] raddr;
	logic [BW-1:0] rd_b;
	logic [UW-1:0] rd_c;

	// Combinational helpers.
	logic [IW:0]   mid_sum;
	logic [IW-1:0] mid;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   mul_p;
	logic [UW:0]   acc_sum;
	logic [UW-1:0] app_c;
	logic [UW-1:0] area_nxt;
	logic [BW-1:0] bnew;
	logic [UW-1:0] val_ext;
	logic          div_start;
	logic [63:0]   div_hi;
	logic [31:0]   div_lo;
	logic [63:0]   div_den;
	logic          div_done;
	logic [32:0]   div_q;
	logic          out_free;

	hics_ram #(.WIDTH(BW), .DEPTH(hics_pkg::DEPTH)) u_bnd_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata_b),
		.raddr (raddr),
		.rdata (rd_b)
	);

	hics_ram #(.WIDTH(UW), .DEPTH(hics_pkg::DEPTH)) u_cum_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata_c),
		.raddr (raddr),
		.rdata (rd_c)
	);

	hics_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.hi     (div_hi),
		.lo     (div_lo),
		.den    (div_den),
		.done   (div_done),
		.q      (div_q)
	);

	// Search midpoint rounds up so the lower bound always moves.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (IW+1)'(1);
	assign mid     = mid_sum[IW:1];

	// Read address selection, shared by both stores.
	always_comb begin
		case (cmd.rd)
			hics_pkg::RD_ZERO: raddr = '0;
			hics_pkg::RD_LAST: raddr = IW'(n_q - CW'(1));
			hics_pkg::RD_MID:  raddr = mid;
			hics_pkg::RD_LO:   raddr = lo_q;
			hics_pkg::RD_LO1:  raddr = lo_q + IW'(1);
			default:           raddr = '0;
		endcase
	end

	// Clamped boundary and new cumulative value of an append.
	assign bnew    = ($signed(x_q) < $signed(bi_q)) ? bi_q : x_q;
	assign val_ext = {32'h0, val_q};
	assign acc_sum = {1'b0, ci_q} + {1'b0, prod_q};
	always_comb begin
		if (cfg_q) begin
			app_c = (val_ext < ci_q) ? ci_q : val_ext;
		end else begin
			app_c = acc_sum[UW] ? '1 : acc_sum[UW-1:0];
		end
	end

	// Cumulative area at x, limited to the bin's upper cumulative value.
	always_comb begin
		if (w_q == '0) begin
			area_nxt = ci_q;
		end else if (acc_sum[UW] || (acc_sum[UW-1:0] > ci1_q)) begin
			area_nxt = ci1_q;
		end else begin
			area_nxt = acc_sum[UW-1:0];
		end
	end

	// Store writes: a new table's first entry or an appended entry.
	always_comb begin
		we      = 1'b0;
		waddr   = IW'(n_q);
		wdata_b = bi1_q;
		wdata_c = app_c;
		if (cmd.op == hics_pkg::OP_START_TABLE) begin
			we      = 1'b1;
			waddr   = '0;
			wdata_b = x_q;
			wdata_c = '0;
		end else if (cmd.op == hics_pkg::OP_APP_WRITE) begin
			we = 1'b1;
		end
	end

	// Shared 32x32 multiplier operands.
	always_comb begin
		case (cmd.op)
			hics_pkg::OP_MUL_APP: begin
				mul_a = val_q;
				mul_b = w_q;
			end
			hics_pkg::OP_MUL_AREA: begin
				mul_a = x_q - bi_q;
				mul_b = h_q;
			end
			hics_pkg::OP_MUL_RHI: begin
				mul_a = u_q;
				mul_b = s_q[63:32];
			end
			hics_pkg::OP_MUL_RLO: begin
				mul_a = u_q;
				mul_b = s_q[31:0];
			end
			hics_pkg::OP_MUL_OFF: begin
				mul_a = f_q[31:0];
				mul_b = w_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Divider operands for each of the four quotients.
	always_comb begin
		div_start = 1'b1;
		div_lo    = '0;
		case (cmd.op)
			hics_pkg::OP_DIV_H: begin
				div_hi  = {32'h0, a_q[63:32]};
				div_lo  = a_q[31:0];
				div_den = {32'h0, w_q};
			end
			hics_pkg::OP_DIV_PDF: begin
				div_hi  = {32'h0, h_q};
				div_den = total_q;
			end
			hics_pkg::OP_DIV_CDF: begin
				div_hi  = area_q;
				div_den = total_q;
			end
			hics_pkg::OP_DIV_F: begin
				div_hi  = r_q - ci_q;
				div_den = a_q;
			end
			default: begin
				div_start = 1'b0;
				div_hi    = '0;
				div_den   = '0;
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	// Status towards the controller.
	always_comb begin
		sts.action     = act_q;
		sts.n_zero     = n_q == '0;
		sts.n_lt2      = n_q < CW'(2);
		sts.n_full     = n_q >= CW'(hics_pkg::DEPTH);
		sts.total_zero = total_q == '0;
		sts.in_range   = ($signed(x_q) >= $signed(b0_q)) && ($signed(x_q) <= $signed(btop_q));
		sts.x_ge_top   = $signed(x_q) >= $signed(btop_q);
		sts.x_le_b0    = $signed(x_q) <= $signed(b0_q);
		sts.use_limit  = lim_q;
		sts.area_zero  = area_q == '0;
		sts.srch_more  = lo_q < hi_q;
		sts.div_done   = div_done;
		sts.out_free   = out_free;
	end

	// Control registers: configuration, entry count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.op == hics_pkg::OP_START_TABLE) begin
				n_q <= CW'(1);
			end else if (cmd.op == hics_pkg::OP_APP_WRITE) begin
				n_q <= n_q + CW'(1);
			end
			if (cmd.op == hics_pkg::OP_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and working registers, one operation per cycle.
	always_ff @(posedge clk) begin
		case (cmd.op)
			hics_pkg::OP_ACCEPT: begin
				act_q   <= hics_pkg::action_t'(in_action);
				x_q     <= in_x;
				val_q   <= in_value;
				u_q     <= in_u;
				lim_q   <= in_use_limit;
				pdf_q   <= '0;
				dens_q  <= '0;
				cdf_q   <= '0;
				drawn_q <= '0;
				bidx_q  <= '0;
				stat_q  <= hics_pkg::STAT_OK;
			end
			hics_pkg::OP_SET_NOT_READY, hics_pkg::OP_SET_ZERO_BIN, hics_pkg::OP_SET_FULL: begin
				pdf_q   <= '0;
				dens_q  <= '0;
				cdf_q   <= '0;
				drawn_q <= '0;
				bidx_q  <= '0;
				if (cmd.op == hics_pkg::OP_SET_NOT_READY) begin
					stat_q <= hics_pkg::STAT_NOT_READY;
				end else if (cmd.op == hics_pkg::OP_SET_ZERO_BIN) begin
					stat_q <= hics_pkg::STAT_ZERO_BIN;
				end else begin
					stat_q <= hics_pkg::STAT_FULL;
				end
			end
			hics_pkg::OP_CAP_TOP: begin
				btop_q  <= rd_b;
				total_q <= rd_c;
			end
			hics_pkg::OP_CAP_B0: begin
				b0_q <= rd_b;
			end
			hics_pkg::OP_CDF_FULL: begin
				cdf_q <= hics_pkg::CDF_ONE;
			end
			hics_pkg::OP_SRCH_INIT: begin
				lo_q <= '0;
				hi_q <= IW'(n_q - CW'(2));
			end
			hics_pkg::OP_SRCH_X: begin
				if ($signed(rd_b) <= $signed(x_q)) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid - IW'(1);
				end
			end
			hics_pkg::OP_SRCH_C: begin
				if (rd_c <= r_q) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid - IW'(1);
				end
			end
			hics_pkg::OP_CAP_LO: begin
				bi_q <= rd_b;
				ci_q <= rd_c;
			end
			hics_pkg::OP_CAP_HI: begin
				bi1_q <= rd_b;
				ci1_q <= rd_c;
			end
			hics_pkg::OP_WIDTH: begin
				w_q <= bi1_q - bi_q;
				a_q <= ci1_q - ci_q;
			end
			hics_pkg::OP_CAP_H: begin
				h_q    <= div_q[32] ? '1 : div_q[31:0];
				dens_q <= div_q[32] ? '1 : div_q[31:0];
			end
			hics_pkg::OP_CAP_PDF: begin
				// A zero-width bin has unbounded density.
				pdf_q <= ((w_q == '0) || div_q[32]) ? '1 : div_q[31:0];
			end
			hics_pkg::OP_AREA: begin
				area_q <= area_nxt;
			end
			hics_pkg::OP_CAP_CDF: begin
				cdf_q <= div_q;
			end
			hics_pkg::OP_LIM_B0: begin
				drawn_q <= b0_q;
				bidx_q  <= '0;
			end
			hics_pkg::OP_SEL_AREA: begin
				s_q <= area_q;
			end
			hics_pkg::OP_SEL_TOTAL: begin
				s_q <= total_q;
			end
			hics_pkg::OP_MUL_RHI, hics_pkg::OP_MUL_AREA, hics_pkg::OP_MUL_OFF,
			hics_pkg::OP_MUL_APP: begin
				prod_q <= mul_p;
			end
			hics_pkg::OP_MUL_RLO: begin
				r_q    <= prod_q;
				prod_q <= mul_p;
			end
			hics_pkg::OP_R_SUM: begin
				r_q  <= r_q + {32'h0, prod_q[63:32]};
				lo_q <= '0;
				hi_q <= IW'(n_q - CW'(2));
			end
			hics_pkg::OP_CAP_F: begin
				// An empty bin places the sample at its lower boundary.
				f_q <= (a_q == '0) ? '0 : div_q;
			end
			hics_pkg::OP_DRAWN: begin
				drawn_q <= bi_q + (f_q[32] ? w_q : prod_q[63:32]);
				bidx_q  <= hics_pkg::BIN_W'(lo_q);
			end
			hics_pkg::OP_APP_BND: begin
				bi1_q <= bnew;
				w_q   <= bnew - bi_q;
			end
			hics_pkg::OP_OUT_LOAD: begin
				opdf_q   <= pdf_q;
				odens_q  <= dens_q;
				ocdf_q   <= cdf_q;
				odrawn_q <= drawn_q;
				obidx_q  <= bidx_q;
				ostat_q  <= stat_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign out_pdf       = opdf_q;
	assign out_density   = odens_q;
	assign out_cdf       = ocdf_q;
	assign out_drawn     = odrawn_q;
	assign out_bin_index = obidx_q;
	assign out_status    = ostat_q;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the histogram inverse-CDF sampler.
module testbench;

	typedef struct {
		hics_pkg::action_t act;
		logic [31:0]       x;
		logic [31:0]       value;
		logic [31:0]       u;
		logic              lim;
	} hist_req_t;

	typedef struct {
		logic [31:0]       pdf;
		logic [31:0]       density;
		logic [32:0]       cdf;
		logic [31:0]       drawn;
		logic [8:0]        bin;
		hics_pkg::status_t status;
	} hist_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic cfg_wdata;

	hics_req_if req ();
	hics_rsp_if rsp ();

	histogram_inverse_cdf_sampler uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	// Requests waiting to be offered, and responses the table model has worked out.
	hist_req_t pending_reqs[$];
	hist_rsp_t predicted_rsps[$];
	int        fail_count;
	int        rsp_count;
	bit        calm;

	// Shadow of the table and of the mode register.
	logic [31:0] bnd_mem [hics_pkg::DEPTH];
	logic [63:0] cum_mem [hics_pkg::DEPTH];
	int          entries;
	bit          cdf_mode;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Table arithmetic, bit for bit.
	function automatic longint sbnd(int i);
		return longint'($signed(bnd_mem[i]));
	endfunction

	function automatic logic [63:0] bin_width(int i);
		return 64'(sbnd(i + 1) - sbnd(i));
	endfunction

	function automatic logic [63:0] bin_area(int i);
		return cum_mem[i + 1] - cum_mem[i];
	endfunction

	function automatic logic [63:0] bin_height(int i);
		logic [63:0] w;
		logic [63:0] h;
		w = bin_width(i);
		if (w == 0)
			return 64'hFFFF_FFFF;
		h = bin_area(i) / w;
		return (h > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : h;
	endfunction

	function automatic logic [63:0] frac_q32(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rem;
		logic        top;
		if (num >= den)
			return 64'h1_0000_0000;
		q = 0;
		rem = num;
		for (int k = 0; k < 32; k++) begin
			top = rem[63];
			rem = rem << 1;
			q = q << 1;
			if (top || rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic int seek_x(longint xv, int n);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = n - 2;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (sbnd(mid) <= xv) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic int seek_c(logic [63:0] r, int n);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = n - 2;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (cum_mem[mid] <= r) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic logic [63:0] area_below(int i, longint xv);
		logic [63:0] dx;
		logic [63:0] p;
		logic [63:0] c;
		dx = 64'(xv - sbnd(i));
		if (bin_width(i) == 0)
			return cum_mem[i];
		p = dx * bin_height(i);
		c = cum_mem[i] + p;
		if (c < p || c > cum_mem[i + 1])
			c = cum_mem[i + 1];
		return c;
	endfunction

	function automatic void draw_sample(logic [63:0] s, logic [31:0] u, int n,
		inout hist_rsp_t res);
		logic [63:0] uw;
		logic [63:0] r;
		logic [63:0] a;
		logic [63:0] f;
		logic [63:0] off;
		int          j;
		uw = {32'h0, u};
		r = uw * (s >> 32) + ((uw * {32'h0, s[31:0]}) >> 32);
		j = seek_c(r, n);
		a = bin_area(j);
		f = 0;
		if (a != 0)
			f = frac_q32(r - cum_mem[j], a);
		off = (f * bin_width(j)) >> 32;
		res.drawn = bnd_mem[j] + off[31:0];
		res.bin = 9'(j);
	endfunction

	// Works out the response to one accepted request and updates the table.
	function automatic hist_rsp_t predict_response(hist_req_t it);
		hist_rsp_t   res;
		longint      xs;
		logic [63:0] total;
		logic [63:0] prev;
		logic [63:0] c;
		logic [63:0] p;
		logic [63:0] h;
		logic [63:0] cmax;
		int          n;
		int          i;
		res = '{pdf: 0, density: 0, cdf: 0, drawn: 0, bin: 0, status: hics_pkg::STAT_OK};
		xs = longint'($signed(it.x));
		n = entries;
		case (it.act)
			hics_pkg::ACT_START: begin
				bnd_mem[0] = it.x;
				cum_mem[0] = 0;
				entries = 1;
				return res;
			end
			hics_pkg::ACT_APPEND: begin
				if (n == 0) begin
					res.status = hics_pkg::STAT_NOT_READY;
					return res;
				end
				if (n >= hics_pkg::DEPTH) begin
					res.status = hics_pkg::STAT_FULL;
					return res;
				end
				bnd_mem[n] = (xs < sbnd(n - 1)) ? bnd_mem[n - 1] : it.x;
				prev = cum_mem[n - 1];
				if (cdf_mode) begin
					c = ({32'h0, it.value} < prev) ? prev : {32'h0, it.value};
				end else begin
					p = {32'h0, it.value} * bin_width(n - 1);
					c = prev + p;
					if (c < p)
						c = '1;
				end
				cum_mem[n] = c;
				entries = n + 1;
				return res;
			end
			hics_pkg::ACT_NOP: return res;
			default: ;
		endcase

		if (n < 2) begin
			res.status = hics_pkg::STAT_NOT_READY;
			return res;
		end
		total = cum_mem[n - 1];
		if (total == 0) begin
			res.status = hics_pkg::STAT_ZERO_BIN;
			return res;
		end

		// Density inside the table range.
		if (xs >= sbnd(0) && xs <= sbnd(n - 1)) begin
			i = seek_x(xs, n);
			h = bin_height(i);
			if (bin_width(i) == 0) begin
				p = 64'hFFFF_FFFF;
			end else begin
				p = (h << 32) / total;
				if (p > 64'hFFFF_FFFF)
					p = 64'hFFFF_FFFF;
			end
			res.pdf = p[31:0];
			res.density = h[31:0];
		end

		// Cumulative probability.
		if (xs < sbnd(0))
			res.cdf = 0;
		else if (xs >= sbnd(n - 1))
			res.cdf = hics_pkg::CDF_ONE;
		else
			res.cdf = 33'(frac_q32(area_below(seek_x(xs, n), xs), total));

		// Sample, possibly limited to values below x.
		if (it.lim && xs < sbnd(n - 1)) begin
			if (xs <= sbnd(0)) begin
				res.drawn = bnd_mem[0];
				res.bin = 0;
				return res;
			end
			cmax = area_below(seek_x(xs, n), xs);
			if (cmax == 0) begin
				res = '{pdf: 0, density: 0, cdf: 0, drawn: 0, bin: 0,
					status: hics_pkg::STAT_ZERO_BIN};
				return res;
			end
			draw_sample(cmax, it.u, n, res);
		end else begin
			draw_sample(total, it.u, n, res);
		end
		return res;
	endfunction

	// Gap lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 60);
	endfunction

	// Request driver.
	int        drv_gap;
	hist_req_t drv_cur;
	always @(posedge clk or negedge arst_n) begin
		hist_req_t nxt;
		bit        busy;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.action <= hics_pkg::ACT_NOP;
			req.x <= '0;
			req.value <= '0;
			req.u <= '0;
			req.use_limit <= 1'b0;
			drv_gap = 0;
		end else begin
			busy = req.valid;
			if (req.valid && req.ready) begin
				predicted_rsps.push_back(predict_response(drv_cur));
				busy = 1'b0;
				drv_gap = pick_gap();
			end
			if (!busy) begin
				if (drv_gap > 0) begin
					drv_gap--;
					req.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					nxt = pending_reqs.pop_front();
					drv_cur = nxt;
					req.valid <= 1'b1;
					req.action <= nxt.act;
					req.x <= nxt.x;
					req.value <= nxt.value;
					req.u <= nxt.u;
					req.use_limit <= nxt.lim;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and ready generator, with one long hold-off.
	int  mon_stall;
	bit  held_once;
	always @(posedge clk or negedge arst_n) begin
		hist_rsp_t e;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			mon_stall = 0;
			held_once = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_count++;
				if (predicted_rsps.size() == 0) begin
					$display("%0t: unexpected response pdf=%h density=%h cdf=%h",
						$time, rsp.pdf, rsp.density, rsp.cdf);
					$display("%0t:          drawn=%h bin=%0d status=%0d",
						$time, rsp.drawn, rsp.bin_index, rsp.status);
					fail_count++;
				end else begin
					e = predicted_rsps.pop_front();
					if (rsp.pdf !== e.pdf || rsp.density !== e.density || rsp.cdf !== e.cdf ||
						rsp.drawn !== e.drawn || rsp.bin_index !== e.bin ||
						rsp.status !== e.status) begin
						$display({"%0t: mismatch expected pdf=%h density=%h cdf=%h",
							" drawn=%h bin=%0d status=%0d"},
							$time, e.pdf, e.density, e.cdf, e.drawn, e.bin, e.status);
						$display({"%0t:          actual   pdf=%h density=%h cdf=%h",
							" drawn=%h bin=%0d status=%0d"},
							$time, rsp.pdf, rsp.density, rsp.cdf, rsp.drawn,
							rsp.bin_index, rsp.status);
						fail_count++;
					end
				end
				if (rsp_count == 150 && !held_once) begin
					held_once = 1;
					mon_stall = 3000;
				end else begin
					mon_stall = pick_gap();
				end
			end
			if (mon_stall > 0) begin
				mon_stall--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Stimulus helpers.
	task automatic put(hics_pkg::action_t a, logic [31:0] xv, logic [31:0] v,
		logic [31:0] uv, bit l);
		pending_reqs.push_back('{act: a, x: xv, value: v, u: uv, lim: l});
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || predicted_rsps.size() > 0 || req.valid)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_mode(bit m);
		wait_idle();
		cfg_wen = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_wen = 1'b0;
		cdf_mode = m;
	endtask

	// Builds a random table of nb bins and queries it nq times; a little noise is mixed in.
	task automatic random_table(int nb, int nq, ref int total_items);
		longint b;
		longint lo;
		longint cum;
		longint span;
		longint xq;
		logic [31:0] v;
		b = (($urandom_range(0, 9) == 0) ? longint'($signed($urandom())) / 256
			: longint'($urandom_range(0, 'h80000)) - 'h40000);
		lo = b;
		cum = 0;
		put(hics_pkg::ACT_START, 32'(b), $urandom(), $urandom(), $urandom_range(0, 1));
		for (int k = 0; k < nb; k++) begin
			if ($urandom_range(0, 11) == 0)
				b = b - $urandom_range(0, 'h10000);
			else if ($urandom_range(0, 11) == 0)
				b = b;
			else
				b = b + $urandom_range(1, 'h40000);
			if (cdf_mode) begin
				if ($urandom_range(0, 9) == 0)
					v = $urandom();
				else begin
					cum = cum + $urandom_range(0, 'h3000_0000);
					if (cum > 'hFFFF_FFFF) cum = 'hFFFF_FFFF;
					v = 32'(cum);
				end
			end else begin
				v = ($urandom_range(0, 9) == 0) ? 32'h0 : ($urandom() >> $urandom_range(0, 31));
			end
			put(hics_pkg::ACT_APPEND, 32'(b), v, $urandom(), $urandom_range(0, 1));
		end
		span = (b > lo) ? b - lo : 1;
		for (int k = 0; k < nq; k++) begin
			if ($urandom_range(0, 7) == 0)
				xq = longint'($signed($urandom()));
			else
				xq = lo - span / 8 + longint'($urandom_range(0, 32'(span + span / 4)));
			put(hics_pkg::ACT_QUERY, 32'(xq), $urandom(), $urandom(), $urandom_range(0, 1));
		end
		if ($urandom_range(0, 3) == 0)
			put(hics_pkg::action_t'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
				$urandom_range(0, 1));
		total_items += nb + nq + 2;
	endtask

	task automatic random_phase(int target);
		int cnt;
		cnt = 0;
		while (cnt < target) begin
			calm = ($urandom_range(0, 4) == 0);
			random_table($urandom_range(1, 8), $urandom_range(2, 10), cnt);
		end
		calm = 0;
	endtask

	initial begin
		int cnt;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 1'b0;
		cdf_mode = 0;
		entries = 0;
		fail_count = 0;
		rsp_count = 0;
		calm = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_mode(0);

		// Directed: empty table, zero total, unsorted and zero-width bins, limits.
		put(hics_pkg::ACT_APPEND, 32'h0001_0000, 32'h0001_0000, 0, 0);
		put(hics_pkg::ACT_QUERY, 0, 0, 0, 0);
		put(hics_pkg::ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		put(hics_pkg::ACT_START, 32'h0, 0, 0, 0);
		put(hics_pkg::ACT_QUERY, 0, 0, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h0001_0000, 32'h0, 0, 0);
		put(hics_pkg::ACT_QUERY, 32'h0000_8000, 0, 32'h8000_0000, 0);
		put(hics_pkg::ACT_APPEND, 32'h0002_0000, 32'h0001_0000, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h0001_8000, 32'h5, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h0003_0000, 32'hFFFF_FFFF, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h0003_0000, 32'h7, 0, 0);
		put(hics_pkg::ACT_QUERY, 32'h0000_8000, 0, 32'h1234_5678, 1);
		put(hics_pkg::ACT_QUERY, 32'h0003_0000, 0, 32'hFFFF_FFFF, 0);
		put(hics_pkg::ACT_QUERY, 32'h0003_0001, 0, 32'h0, 0);
		put(hics_pkg::ACT_QUERY, 32'h8000_0000, 0, 32'h9999_9999, 1);
		put(hics_pkg::ACT_QUERY, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1);
		put(hics_pkg::ACT_QUERY, 32'h0002_8000, 0, 32'hFFFF_FFFF, 1);
		// Extreme boundaries and large cumulative values.
		put(hics_pkg::ACT_START, 32'h8000_0000, 0, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h0, 32'hFFFF_FFFF, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		put(hics_pkg::ACT_QUERY, 32'h4000_0000, 0, 32'hFFFF_FFFF, 1);
		put(hics_pkg::ACT_QUERY, 32'h7FFF_FFFF, 0, 32'h0, 0);
		random_phase(250);

		// Cumulative-value mode, including a decreasing value.
		set_mode(1);
		put(hics_pkg::ACT_START, 32'hFFFF_0000, 0, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h0, 32'h4000_0000, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h0001_0000, 32'h2000_0000, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h0002_0000, 32'hFFFF_FFFF, 0, 0);
		put(hics_pkg::ACT_QUERY, 32'h0000_8000, 0, 32'hC000_0000, 1);
		put(hics_pkg::ACT_QUERY, 32'h0001_8000, 0, 32'h8000_0000, 0);
		random_phase(200);

		// Height mode: a full table, then appends past the end.
		set_mode(0);
		put(hics_pkg::ACT_START, 32'hFF00_0000, 0, 0, 0);
		for (int k = 1; k < hics_pkg::DEPTH; k++)
			put(hics_pkg::ACT_APPEND, 32'hFF00_0000 + 32'(k) * 32'h800,
				$urandom() >> $urandom_range(8, 31), 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h7FFF_0000, 32'h100, 0, 0);
		put(hics_pkg::ACT_APPEND, 32'h7FFF_0000, 32'h100, 0, 0);
		for (int k = 0; k < 12; k++)
			put(hics_pkg::ACT_QUERY, 32'hFF00_0000 + $urandom_range(0, 'h8_4000), 0,
				$urandom(), $urandom_range(0, 1));
		random_phase(100);

		set_mode(1);
		random_phase(100);

		wait_idle();
		repeat (250) @(negedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#40000000;
		$display("tb: failure");
		$finish;
	end

endmodule
